// File: src/qsf_pkg.sv
// Package for the quintic switching function block: widths, stage map and
// the item kind carried down the pipeline. No dependencies.
package qsf_pkg;

	// Fraction bits of the normalized distance and of both weights.
	localparam int FRAC_BITS = 16;
	// Width of distances and limits (signed Q16.16).
	localparam int DATA_W = 32;
	// Width of one weight field (unsigned Q1.FRAC_BITS).
	localparam int WGT_W = FRAC_BITS + 1;
	// Output word: two weights, padded to whole bytes.
	localparam int OUT_TDATA_W = ((2 * WGT_W + 7) / 8) * 8;
	// Width of the signed polynomial sum before clamping.
	localparam int POLY_W = FRAC_BITS + 6;

	// Stage map: one front stage, one divider stage per quotient bit,
	// four power stages, one polynomial and clamp stage.
	localparam int DIV_FIRST = 1;
	localparam int MUL_FIRST = DIV_FIRST + FRAC_BITS;
	localparam int FIN_STG   = MUL_FIRST + 4;
	localparam int NSTG      = FIN_STG + 1;

	// Configuration register indexes.
	localparam logic REG_LOWER = 1'b0;
	localparam logic REG_UPPER = 1'b1;

	localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << FRAC_BITS;

	// What the final stage produces for an item.
	typedef enum logic [1:0] {
		KIND_ZERO,  // at or above the upper limit
		KIND_ONE,   // at or below the lower limit
		KIND_POLY   // strictly between the limits
	} kind_t;

endpackage

// File: src/quintic_switching_function_top.sv
// Top level of the quintic switching function block: front compare stage,
// bit-per-stage restoring divider, power chain and polynomial clamp.
// Depends on qsf_pkg.
//
// An accepted input word passes through the front stage, one divider stage per
// quotient bit, the power stages and the final stage. Throughput: one word per
// cycle while m_tready holds; every stage moves on its own as soon as the stage
// below it is empty or moving, so bubbles are squeezed out under stall.
// Reset: arst_n clears all stage valid bits at once and loads the limits with
// lower 0.0 and upper 1.0; the block accepts words as soon as reset is released.
module quintic_switching_function_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration write port.
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [qsf_pkg::DATA_W-1:0]        cfg_data,
	// Input stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [qsf_pkg::DATA_W-1:0]        s_tdata,   // [31:0] distance
	// Output stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [qsf_pkg::OUT_TDATA_W-1:0]   m_tdata    // [16:0] weight_off,
	                                                     // [33:17] weight_on, then zeros
);
	import qsf_pkg::*;

	// Configuration registers.
	logic [DATA_W-1:0] lower_q;
	logic [DATA_W-1:0] upper_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= '0;
			upper_q <= DATA_W'(1) << FRAC_BITS;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOWER: lower_q <= cfg_data;
				REG_UPPER: upper_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Per-stage valid bits and the ready chain. A stage may load when it is
	// empty or when the stage after it is taking its word this cycle.
	logic [NSTG-1:0] vld_q;
	logic [NSTG:0]   rdy;
	logic [NSTG-1:0] vin;

	always_comb begin
		rdy[NSTG] = m_tready;
		for (int i = NSTG - 1; i >= 0; i--) begin
			rdy[i] = !vld_q[i] || rdy[i+1];
		end
		vin[0] = s_tvalid;
		for (int i = 1; i < NSTG; i++) begin
			vin[i] = vld_q[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < NSTG; i++) begin
				if (rdy[i]) begin
					vld_q[i] <= vin[i];
				end
			end
		end
	end

	assign s_tready = rdy[0];
	assign m_tvalid = vld_q[FIN_STG];

	// ------------------------------------------------------------------
	// Stage 1: limit tests at full signed width and the two differences.
	// Between the limits both differences are positive and fit in 32 bits.
	// ------------------------------------------------------------------
	logic signed [DATA_W:0] num_w;
	logic signed [DATA_W:0] den_w;
	logic                   hi_hit;
	logic                   lo_hit;
	kind_t                  kind_w;

	always_comb begin
		num_w  = $signed({upper_q[DATA_W-1], upper_q}) - $signed({s_tdata[DATA_W-1], s_tdata});
		den_w  = $signed({upper_q[DATA_W-1], upper_q}) - $signed({lower_q[DATA_W-1], lower_q});
		hi_hit = $signed(s_tdata) >= $signed(upper_q);
		lo_hit = $signed(s_tdata) <= $signed(lower_q);
		// The upper test wins when both hold.
		priority if (hi_hit) begin
			kind_w = KIND_ZERO;
		end else if (lo_hit) begin
			kind_w = KIND_ONE;
		end else begin
			kind_w = KIND_POLY;
		end
	end

	kind_t             kind_s1;
	logic [DATA_W-1:0] num_s1;
	logic [DATA_W-1:0] den_s1;

	always_ff @(posedge clk) begin
		if (rdy[0] && vin[0]) begin
			kind_s1 <= kind_w;
			num_s1  <= num_w[DATA_W-1:0];
			den_s1  <= den_w[DATA_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Stage group 2: restoring division, one quotient bit per stage. For items
	// strictly between the limits the partial remainder always stays below the divisor.
	// ------------------------------------------------------------------
	kind_t                kind_s2 [FRAC_BITS];
	logic [DATA_W-1:0]    rem_s2  [FRAC_BITS];
	logic [DATA_W-1:0]    den_s2  [FRAC_BITS];
	logic [FRAC_BITS-1:0] quo_s2  [FRAC_BITS];

	logic [DATA_W-1:0]    rem_in  [FRAC_BITS];
	logic [DATA_W-1:0]    den_in  [FRAC_BITS];
	logic [FRAC_BITS-1:0] quo_in  [FRAC_BITS];
	kind_t                kind_in [FRAC_BITS];
	logic [DATA_W:0]      rem_dbl [FRAC_BITS];
	logic [DATA_W:0]      rem_sub [FRAC_BITS];
	logic [DATA_W-1:0]    rem_n   [FRAC_BITS];
	logic [FRAC_BITS-1:0] quo_n   [FRAC_BITS];

	always_comb begin
		for (int k = 0; k < FRAC_BITS; k++) begin
			if (k == 0) begin
				rem_in[k]  = num_s1;
				den_in[k]  = den_s1;
				quo_in[k]  = '0;
				kind_in[k] = kind_s1;
			end else begin
				rem_in[k]  = rem_s2[k-1];
				den_in[k]  = den_s2[k-1];
				quo_in[k]  = quo_s2[k-1];
				kind_in[k] = kind_s2[k-1];
			end
			rem_dbl[k] = {rem_in[k], 1'b0};
			rem_sub[k] = rem_dbl[k] - {1'b0, den_in[k]};
			if (rem_dbl[k] >= {1'b0, den_in[k]}) begin
				rem_n[k] = rem_sub[k][DATA_W-1:0];
				quo_n[k] = {quo_in[k][FRAC_BITS-2:0], 1'b1};
			end else begin
				rem_n[k] = rem_dbl[k][DATA_W-1:0];
				quo_n[k] = {quo_in[k][FRAC_BITS-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < FRAC_BITS; k++) begin
			if (rdy[DIV_FIRST+k] && vin[DIV_FIRST+k]) begin
				rem_s2[k]  <= rem_n[k];
				den_s2[k]  <= den_in[k];
				quo_s2[k]  <= quo_n[k];
				kind_s2[k] <= kind_in[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stages 3 to 6: truncated powers u^2 .. u^5, one multiply per stage.
	// ------------------------------------------------------------------
	logic [FRAC_BITS-1:0]   u_div;
	kind_t                  kind_div;
	assign u_div    = quo_s2[FRAC_BITS-1];
	assign kind_div = kind_s2[FRAC_BITS-1];

	logic [2*FRAC_BITS-1:0] p2_w, p3_w, p4_w, p5_w;

	kind_t                kind_s3, kind_s4, kind_s5, kind_s6;
	logic [FRAC_BITS-1:0] u_s3, u2_s3;
	logic [FRAC_BITS-1:0] u_s4, u3_s4;
	logic [FRAC_BITS-1:0] u_s5, u3_s5, u4_s5;
	logic [FRAC_BITS-1:0] u3_s6, u4_s6, u5_s6;

	assign p2_w = {{FRAC_BITS{1'b0}}, u_div} * {{FRAC_BITS{1'b0}}, u_div};
	assign p3_w = {{FRAC_BITS{1'b0}}, u2_s3} * {{FRAC_BITS{1'b0}}, u_s3};
	assign p4_w = {{FRAC_BITS{1'b0}}, u3_s4} * {{FRAC_BITS{1'b0}}, u_s4};
	assign p5_w = {{FRAC_BITS{1'b0}}, u4_s5} * {{FRAC_BITS{1'b0}}, u_s5};

	always_ff @(posedge clk) begin
		if (rdy[MUL_FIRST] && vin[MUL_FIRST]) begin
			kind_s3 <= kind_div;
			u_s3    <= u_div;
			u2_s3   <= p2_w[2*FRAC_BITS-1:FRAC_BITS];
		end
		if (rdy[MUL_FIRST+1] && vin[MUL_FIRST+1]) begin
			kind_s4 <= kind_s3;
			u_s4    <= u_s3;
			u3_s4   <= p3_w[2*FRAC_BITS-1:FRAC_BITS];
		end
		if (rdy[MUL_FIRST+2] && vin[MUL_FIRST+2]) begin
			kind_s5 <= kind_s4;
			u_s5    <= u_s4;
			u3_s5   <= u3_s4;
			u4_s5   <= p4_w[2*FRAC_BITS-1:FRAC_BITS];
		end
		if (rdy[MUL_FIRST+3] && vin[MUL_FIRST+3]) begin
			kind_s6 <= kind_s5;
			u3_s6   <= u3_s5;
			u4_s6   <= u4_s5;
			u5_s6   <= p5_w[2*FRAC_BITS-1:FRAC_BITS];
		end
	end

	// ------------------------------------------------------------------
	// Stage 7: s = 10u^3 - 15u^4 + 6u^5 by shifts and adds, clamped to 0..1,
	// then the limit cases override it.
	// ------------------------------------------------------------------
	logic signed [POLY_W-1:0] a3, a4, a5, poly_w;
	logic [WGT_W-1:0]         woff_w;

	always_comb begin
		a3 = $signed(POLY_W'(u3_s6));
		a4 = $signed(POLY_W'(u4_s6));
		a5 = $signed(POLY_W'(u5_s6));
		poly_w = (a3 <<< 3) + (a3 <<< 1) - ((a4 <<< 4) - a4) + (a5 <<< 2) + (a5 <<< 1);
		unique case (kind_s6)
			KIND_ZERO: woff_w = '0;
			KIND_ONE:  woff_w = WGT_ONE;
			KIND_POLY: begin
				priority if (poly_w < 0) begin
					woff_w = '0;
				end else if (poly_w > $signed(POLY_W'(WGT_ONE))) begin
					woff_w = WGT_ONE;
				end else begin
					woff_w = poly_w[WGT_W-1:0];
				end
			end
			default: woff_w = '0;
		endcase
	end

	logic [WGT_W-1:0] woff_s7;
	logic [WGT_W-1:0] won_s7;
	kind_t            kind_s7;

	always_ff @(posedge clk) begin
		if (rdy[FIN_STG] && vin[FIN_STG]) begin
			woff_s7 <= woff_w;
			won_s7  <= WGT_ONE - woff_w;
			kind_s7 <= kind_s6;
		end
	end

	assign m_tdata = {(OUT_TDATA_W - 2 * WGT_W)'(0), won_s7, woff_s7};

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_wgt_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (WGT_W'(woff_s7 + won_s7) == WGT_ONE))
		else $error("weights do not sum to one");

	a_wgt_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (woff_s7 <= WGT_ONE))
		else $error("switch-off weight above one");

	a_kind_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && kind_s7 == KIND_ZERO) |-> (woff_s7 == '0))
		else $error("upper limit case gave nonzero weight");

	a_kind_one: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && kind_s7 == KIND_ONE) |-> (woff_s7 == WGT_ONE))
		else $error("lower limit case gave weight other than one");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> vld_q[0])
		else $error("accepted word did not enter the front stage");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[FIN_STG - 1] && !rdy[FIN_STG]) |=> vld_q[FIN_STG - 1])
		else $error("stalled word dropped before the output stage");

endmodule
